FILE: src/joystick_moving_average_deadzone_macros.svh
// Assertion macros for the filter's top-level RTL file.
`ifndef JOYSTICK_MOVING_AVERAGE_DEADZONE_MACROS_SVH
`define JOYSTICK_MOVING_AVERAGE_DEADZONE_MACROS_SVH
`ifndef ASSERT_OFF
`define JMAD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define JMAD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define JMAD_ASSERT(lbl, clk, rst_n, prop)
`define JMAD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: src/jmad_pkg.sv
`timescale 1ns / 1ps
package jmad_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PCT_W    = 8;
	localparam int FS_W     = 16;
	localparam int DZ_W     = 15;
	localparam int CHANNELS = 4;
	localparam int CH_W     = 2;

	// Shared divider: the widest dividend is a 16-bit magnitude times 100.
	localparam int QUO_W = 23;
	localparam int DVS_W = 16;

	localparam logic [6:0]        PCT_SCALE = 7'd100;
	localparam logic [QUO_W-1:0]  PCT_LIMIT = 23'd100;

	localparam logic [CH_W-1:0] CH_X    = 2'd0;
	localparam logic [CH_W-1:0] CH_Y    = 2'd1;
	localparam logic [CH_W-1:0] CH_B1   = 2'd2;
	localparam logic [CH_W-1:0] CH_B2   = 2'd3;
	localparam logic [CH_W-1:0] CH_LAST = CH_B2;

	localparam logic REG_FULL_SCALE = 1'b0;
	localparam logic REG_DEAD_ZONE  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_SUM,
		ST_MEAN,
		ST_MAP,
		ST_MUL,
		ST_MAP_GO,
		ST_MAP_WAIT,
		ST_NEXT,
		ST_DONE
	} jmad_state_t;

endpackage

FILE: src/jmad_if.sv
`timescale 1ns / 1ps
interface jmad_frame_if;
	import jmad_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] axis_x_sample;
	logic [SAMPLE_W-1:0] axis_y_sample;
	logic [SAMPLE_W-1:0] battery_one_sample;
	logic [SAMPLE_W-1:0] battery_two_sample;

	modport source (output valid, axis_x_sample, axis_y_sample, battery_one_sample,
		battery_two_sample, input ready);
	modport sink (input valid, axis_x_sample, axis_y_sample, battery_one_sample,
		battery_two_sample, output ready);
endinterface

interface jmad_result_if;
	import jmad_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [PCT_W-1:0] axis_x_percent;
	logic signed [PCT_W-1:0] axis_y_percent;
	logic [SAMPLE_W-1:0]     battery_one_level;
	logic [SAMPLE_W-1:0]     battery_two_level;

	modport source (output valid, axis_x_percent, axis_y_percent, battery_one_level,
		battery_two_level, input ready);
	modport sink (input valid, axis_x_percent, axis_y_percent, battery_one_level,
		battery_two_level, output ready);
endinterface

FILE: src/jmad_ram.sv
`timescale 1ns / 1ps
module jmad_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/jmad_div.sv
`timescale 1ns / 1ps
module jmad_div #(
	parameter int DVD_W = 23,
	parameter int DVS_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	// Restoring division, one quotient bit per cycle, most significant first.
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: src/joystick_moving_average_deadzone.sv
`timescale 1ns / 1ps
// Moving-average filter for a four-channel converter frame (joystick X and Y, two battery
// channels) with a dead-band percent mapping of the joystick axes. Frames come in on the
// frame channel, one filtered result per frame leaves on the result channel, and the
// result register lets the next frame be taken while a result still waits. The block
// works on one frame at a time; the first frame after reset fills every slot of the
// sample RAM with that frame. The time a frame takes is set by the single sample RAM
// read port, once per stored sample, and by the shared radix-2 divider, which forms each
// axis percent; the channel means come from a constant reciprocal multiply. An axis inside
// the dead band, or with a band at least half of full scale, skips its divider pass.
// Registers on the APB port: full_scale at 0x0, dead_zone at 0x4; write them only
// while idle.
`include "joystick_moving_average_deadzone_macros.svh"
module joystick_moving_average_deadzone #(
	parameter int FILTER_LEN = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	jmad_frame_if.sink    frame,
	jmad_result_if.source result
);
	import jmad_pkg::*;

	localparam int POS_W  = $clog2(FILTER_LEN);
	localparam int DEPTH  = CHANNELS * FILTER_LEN;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SUM_W  = SAMPLE_W + $clog2(FILTER_LEN);
	localparam logic [POS_W-1:0] LAST = POS_W'(FILTER_LEN - 1);
	// Floor of sum / FILTER_LEN as (sum * MEAN_RCP) >> MEAN_SH, exact for any SUM_W-bit sum.
	localparam int MEAN_SH = SUM_W + $clog2(FILTER_LEN);
	localparam int RCP_W   = SUM_W + 1;
	localparam int MUL_W   = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] MEAN_RCP = RCP_W'(((longint'(1) << MEAN_SH)
		+ longint'(FILTER_LEN) - 1) / longint'(FILTER_LEN));

	jmad_state_t state_q, state_d;

	logic [FS_W-1:0]     full_scale_q;
	logic [DZ_W-1:0]     dead_zone_q;
	logic [SAMPLE_W-1:0] smp_q [CHANNELS];
	logic                primed_q;
	logic                fill_q;
	logic [POS_W-1:0]    pos_q;
	logic [CH_W-1:0]     ch_q;
	logic [POS_W-1:0]    idx_q;
	logic                rd_pend_q;
	logic [SUM_W-1:0]    acc_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [SAMPLE_W-1:0] mag_q;
	logic                neg_q;
	logic                zero_q;
	logic [QUO_W-1:0]    prod_q;
	logic [PCT_W-1:0]    pct_q [2];
	logic [SAMPLE_W-1:0] lvl_q [2];
	logic                out_valid_q;
	logic [PCT_W-1:0]    out_x_q;
	logic [PCT_W-1:0]    out_y_q;
	logic [SAMPLE_W-1:0] out_b1_q;
	logic [SAMPLE_W-1:0] out_b2_q;

	logic                cfg_wr;
	logic                accept;
	logic                wr_last;
	logic                out_ld;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [SAMPLE_W-1:0] ram_rdata;
	logic                div_start;
	logic [QUO_W-1:0]    div_dividend;
	logic [DVS_W-1:0]    div_divisor;
	logic                div_done;
	logic [QUO_W-1:0]    div_quotient;
	logic [MUL_W-1:0]    mean_prod;
	logic [SAMPLE_W-1:0] mean_val;
	logic                pct_ok;

	logic [DZ_W-1:0]     half;
	logic signed [16:0]  span;
	logic                span_pos;
	logic signed [17:0]  centred;
	logic signed [17:0]  dz_s;
	logic signed [17:0]  above;
	logic signed [17:0]  below;
	logic                is_above;
	logic                is_below;
	logic [6:0]          sat;
	logic [PCT_W-1:0]    pct_val;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_DEAD_ZONE) ? {17'd0, dead_zone_q} : {16'd0, full_scale_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= 16'd4095;
			dead_zone_q  <= 15'd100;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_FULL_SCALE) begin
				full_scale_q <= pwdata[FS_W-1:0];
			end else begin
				dead_zone_q <= pwdata[DZ_W-1:0];
			end
		end
	end

	assign mean_prod = MUL_W'(acc_q) * MUL_W'(MEAN_RCP);
	assign mean_val  = mean_prod[MEAN_SH +: SAMPLE_W];

	// Axis mapping arithmetic on the registered mean.
	always_comb begin
		half     = full_scale_q[FS_W-1:1];
		span     = $signed({2'b00, half}) - $signed({2'b00, dead_zone_q});
		span_pos = !span[16] && (span != 17'sd0);
		centred  = $signed({2'b00, avg_q}) - $signed({3'b000, half});
		dz_s     = $signed({3'b000, dead_zone_q});
		above    = centred - dz_s;
		below    = 18'sd0 - centred - dz_s;
		is_above = centred > dz_s;
		is_below = centred < (18'sd0 - dz_s);
		sat      = (div_quotient > PCT_LIMIT) ? PCT_SCALE : div_quotient[6:0];
		pct_val  = neg_q ? (8'd0 - {1'b0, sat}) : {1'b0, sat};
	end

	assign wr_last = (ch_q == CH_LAST) && (!fill_q || (idx_q == LAST));
	assign accept  = frame.valid && frame.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (frame.valid) state_d = ST_WRITE;
			ST_WRITE:     if (wr_last) state_d = ST_READ;
			ST_READ:      if (idx_q == LAST) state_d = ST_SUM;
			ST_SUM:       state_d = ST_MEAN;
			ST_MEAN:      state_d = ch_q[1] ? ST_NEXT : ST_MAP;
			ST_MAP:       state_d = ST_MUL;
			ST_MUL:       state_d = zero_q ? ST_NEXT : ST_MAP_GO;
			ST_MAP_GO:    state_d = ST_MAP_WAIT;
			ST_MAP_WAIT:  if (div_done) state_d = ST_NEXT;
			ST_NEXT:      state_d = (ch_q == CH_LAST) ? ST_DONE : ST_READ;
			ST_DONE:      if (!out_valid_q || result.ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		ram_we       = 1'b0;
		div_start    = 1'b0;
		div_dividend = prod_q;
		div_divisor  = span[DVS_W-1:0];
		out_ld       = 1'b0;
		ram_waddr    = ADDR_W'(32'(ch_q) * FILTER_LEN + 32'(fill_q ? idx_q : pos_q));
		ram_raddr    = ADDR_W'(32'(ch_q) * FILTER_LEN + 32'(idx_q));
		case (state_q)
			ST_WRITE:   ram_we = 1'b1;
			ST_MAP_GO:  div_start = 1'b1;
			ST_DONE:    out_ld = !out_valid_q || result.ready;
			default:    ram_we = 1'b0;
		endcase
	end

	assign frame.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			primed_q    <= 1'b0;
			fill_q      <= 1'b0;
			pos_q       <= '0;
			ch_q        <= '0;
			idx_q       <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= (state_q == ST_READ);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q <= !primed_q;
						ch_q   <= '0;
						idx_q  <= '0;
					end
				end
				ST_WRITE: begin
					if (wr_last) begin
						ch_q  <= '0;
						idx_q <= '0;
						if (fill_q) begin
							primed_q <= 1'b1;
						end else begin
							pos_q <= (pos_q == LAST) ? '0 : pos_q + 1'b1;
						end
					end else if (fill_q && (idx_q != LAST)) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						idx_q <= '0;
						ch_q  <= ch_q + 1'b1;
					end
				end
				ST_READ:  idx_q <= (idx_q == LAST) ? '0 : idx_q + 1'b1;
				ST_NEXT: begin
					if (ch_q != CH_LAST) begin
						ch_q <= ch_q + 1'b1;
					end
					idx_q <= '0;
				end
				default:  idx_q <= idx_q;
			endcase
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q[CH_X]  <= frame.axis_x_sample;
			smp_q[CH_Y]  <= frame.axis_y_sample;
			smp_q[CH_B1] <= frame.battery_one_sample;
			smp_q[CH_B2] <= frame.battery_two_sample;
		end
		// Each read returns in the cycle after its address, so rd_pend_q delays the sum to match.
		if (rd_pend_q) begin
			acc_q <= acc_q + SUM_W'(ram_rdata);
		end else if (state_q == ST_WRITE || state_q == ST_NEXT) begin
			acc_q <= '0;
		end
		if (state_q == ST_MEAN) begin
			avg_q <= mean_val;
			if (ch_q[1]) begin
				lvl_q[ch_q[0]] <= mean_val;
			end
		end
		if (state_q == ST_MAP) begin
			mag_q  <= is_above ? above[SAMPLE_W-1:0] : below[SAMPLE_W-1:0];
			neg_q  <= !is_above;
			zero_q <= !span_pos || !(is_above || is_below);
		end
		if (state_q == ST_MUL) begin
			prod_q <= {7'd0, mag_q} * {16'd0, PCT_SCALE};
			if (zero_q) begin
				pct_q[ch_q[0]] <= '0;
			end
		end
		if (state_q == ST_MAP_WAIT && div_done) begin
			pct_q[ch_q[0]] <= pct_val;
		end
		if (out_ld) begin
			out_x_q  <= pct_q[0];
			out_y_q  <= pct_q[1];
			out_b1_q <= lvl_q[0];
			out_b2_q <= lvl_q[1];
		end
	end

	jmad_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(smp_q[ch_q]),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	jmad_div #(
		.DVD_W(QUO_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quotient)
	);

	assign result.valid             = out_valid_q;
	assign result.axis_x_percent    = $signed(out_x_q);
	assign result.axis_y_percent    = $signed(out_y_q);
	assign result.battery_one_level = out_b1_q;
	assign result.battery_two_level = out_b2_q;

	assign pct_ok = ($signed(out_x_q) <= 8'sd100) && ($signed(out_x_q) >= -8'sd100)
		&& ($signed(out_y_q) <= 8'sd100) && ($signed(out_y_q) >= -8'sd100);

	`JMAD_ASSERT(a_primed_sticks, clk, arst_n, primed_q |=> primed_q)
	`JMAD_ASSERT(a_pos_in_ring, clk, arst_n, pos_q <= LAST)
	`JMAD_ASSERT(a_div_done_waited, clk, arst_n, div_done |-> (state_q == ST_MAP_WAIT))
	`JMAD_ASSERT(a_pct_range, clk, arst_n, result.valid |-> pct_ok)
	`JMAD_ASSERT_NEVER(a_no_write_after_read, clk, arst_n, ram_we && rd_pend_q)

endmodule

FILE: tb/sv/jmad_filter_check.sv
`timescale 1ns / 1ps
module jmad_filter_check
	import jmad_pkg::*;
#(
	parameter int FILTER_LEN = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	jmad_frame_if       frame,
	jmad_result_if      result,
	output int          error_count,
	output int          outstanding
);

	localparam longint PCT_FULL = 100;

	typedef struct packed {
		logic signed [PCT_W-1:0] x_pct;
		logic signed [PCT_W-1:0] y_pct;
		logic [SAMPLE_W-1:0]     b1_level;
		logic [SAMPLE_W-1:0]     b2_level;
	} filtered_t;

	logic [FS_W-1:0]     full_scale_q = 16'd4095;
	logic [DZ_W-1:0]     dead_zone_q = 15'd100;
	logic [SAMPLE_W-1:0] ring_store [CHANNELS][FILTER_LEN];
	int unsigned         ring_slot = 0;
	logic                primed = 1'b0;
	filtered_t           awaited_results [$];
	filtered_t           want;
	filtered_t           seen;
	logic [SAMPLE_W-1:0] codes [CHANNELS];
	logic [31:0]         reg_value;
	int                  errors = 0;

	assign error_count = errors;

	function automatic logic [SAMPLE_W-1:0] ring_mean(int ch);
		int unsigned acc;
		acc = 0;
		for (int i = 0; i < FILTER_LEN; i++)
			acc += ring_store[ch][i];
		return SAMPLE_W'(acc / FILTER_LEN);
	endfunction

	// Centre on half of full scale, then scale the part outside the dead band.
	function automatic logic signed [PCT_W-1:0] deflection(logic [SAMPLE_W-1:0] mean_code);
		longint half;
		longint band;
		longint span;
		longint off;
		longint pct;
		half = full_scale_q >> 1;
		band = dead_zone_q;
		span = half - band;
		off = longint'(mean_code) - half;
		if (span <= 0)
			return '0;
		if (off > band)
			pct = ((off - band) * PCT_FULL) / span;
		else if (off < -band)
			pct = ((off + band) * PCT_FULL) / span;
		else
			return '0;
		if (pct > PCT_FULL)
			pct = PCT_FULL;
		if (pct < -PCT_FULL)
			pct = -PCT_FULL;
		return pct[PCT_W-1:0];
	endfunction

	function automatic int field_differs(string name, logic signed [16:0] want_v,
			logic signed [16:0] seen_v);
		if (seen_v === want_v)
			return 0;
		$display("%0t: %s expected %0d, got %0d", $time, name, want_v, seen_v);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q = 16'd4095;
			dead_zone_q = 15'd100;
			ring_slot = 0;
			primed = 1'b0;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_DEAD_ZONE)
						dead_zone_q = pwdata[DZ_W-1:0];
					else
						full_scale_q = pwdata[FS_W-1:0];
				end else begin
					reg_value = (paddr[2] == REG_DEAD_ZONE) ? 32'(dead_zone_q)
						: 32'(full_scale_q);
					if (prdata !== reg_value) begin
						$display("%0t: register read at %0d expected %0d, got %0d",
							$time, paddr, reg_value, prdata);
						errors++;
					end
				end
			end

			if (result.valid === 1'b1 && result.ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with no frame outstanding, expected none, got %0d %0d %0d %0d",
						$time, result.axis_x_percent, result.axis_y_percent,
						result.battery_one_level, result.battery_two_level);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					seen.x_pct = result.axis_x_percent;
					seen.y_pct = result.axis_y_percent;
					seen.b1_level = result.battery_one_level;
					seen.b2_level = result.battery_two_level;
					errors += field_differs("axis_x_percent", want.x_pct, seen.x_pct);
					errors += field_differs("axis_y_percent", want.y_pct, seen.y_pct);
					errors += field_differs("battery_one_level", want.b1_level, seen.b1_level);
					errors += field_differs("battery_two_level", want.b2_level, seen.b2_level);
				end
			end

			// Each accepted request updates the rings and yields exactly one result.
			if (frame.valid === 1'b1 && frame.ready === 1'b1) begin
				codes[CH_X] = frame.axis_x_sample;
				codes[CH_Y] = frame.axis_y_sample;
				codes[CH_B1] = frame.battery_one_sample;
				codes[CH_B2] = frame.battery_two_sample;
				if (!primed) begin
					for (int ch = 0; ch < CHANNELS; ch++)
						for (int i = 0; i < FILTER_LEN; i++)
							ring_store[ch][i] = codes[ch];
					primed = 1'b1;
				end else begin
					for (int ch = 0; ch < CHANNELS; ch++)
						ring_store[ch][ring_slot] = codes[ch];
					ring_slot = (ring_slot == FILTER_LEN - 1) ? 0 : ring_slot + 1;
				end
				want.x_pct = deflection(ring_mean(CH_X));
				want.y_pct = deflection(ring_mean(CH_Y));
				want.b1_level = ring_mean(CH_B1);
				want.b2_level = ring_mean(CH_B2);
				awaited_results.push_back(want);
			end

			outstanding <= awaited_results.size();
		end
	end

endmodule

FILE: tb/sv/tb_joystick_moving_average_deadzone.sv
`timescale 1ns / 1ps
module tb_joystick_moving_average_deadzone;
	import jmad_pkg::*;

	localparam int FILTER_LEN = 8;
	localparam int PHASES = 16;
	localparam int FRAMES_PER_PHASE = 95;
	localparam int SETTLE_CYCLES = 400;
	localparam logic [2:0] ADDR_FULL_SCALE = {REG_FULL_SCALE, 2'b00};
	localparam logic [2:0] ADDR_DEAD_ZONE = {REG_DEAD_ZONE, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          error_count;
	int          outstanding;
	bit          calm = 1'b0;
	int          stall_left = 0;
	int          scale = 4095;
	int          band = 100;
	int          aim_x;
	int          aim_y;

	jmad_frame_if  frame_ch ();
	jmad_result_if result_ch ();

	joystick_moving_average_deadzone #(
		.FILTER_LEN(FILTER_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.frame(frame_ch),
		.result(result_ch)
	);

	jmad_filter_check #(
		.FILTER_LEN(FILTER_LEN)
	) filter_check (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.frame(frame_ch),
		.result(result_ch),
		.error_count(error_count),
		.outstanding(outstanding)
	);

	always #6 clk = ~clk;

	initial begin : watchdog
		#40_000_000;
		$display("tb_joystick_moving_average_deadzone: done, errors");
		$finish;
	end

	function automatic int idle_len();
		int pick;
		if (calm)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int clamp_code(int v);
		if (v < 0)
			return 0;
		if (v > 65535)
			return 65535;
		return v;
	endfunction

	// Joystick targets cluster around the centre and the rims of the dead band.
	function automatic int pick_aim();
		int centre;
		int reach;
		int rim;
		centre = scale / 2;
		reach = band + scale / 16 + 4;
		rim = $urandom_range(0, 1) ? band : -band;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return clamp_code(centre - reach + int'($urandom_range(0, 2 * reach)));
			4: return clamp_code(centre + rim + int'($urandom_range(0, 4)) - 2);
			5, 6, 7: return $urandom_range(0, scale);
			8: return $urandom_range(0, 65535);
			default: begin
				case ($urandom_range(0, 2))
					0: return 0;
					1: return 65535;
					default: return scale;
				endcase
			end
		endcase
	endfunction

	function automatic logic [15:0] battery_code();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 16'h0000;
		if (pick == 1)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_frame(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] b1, input logic [15:0] b2);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			frame_ch.valid <= 1'b0;
			frame_ch.axis_x_sample <= 16'($urandom);
			frame_ch.axis_y_sample <= 16'($urandom);
			frame_ch.battery_one_sample <= 16'($urandom);
			frame_ch.battery_two_sample <= 16'($urandom);
			repeat (gap) @(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.axis_x_sample <= x;
		frame_ch.axis_y_sample <= y;
		frame_ch.battery_one_sample <= b1;
		frame_ch.battery_two_sample <= b2;
		do @(posedge clk); while (frame_ch.ready !== 1'b1);
	endtask

	task automatic send_random_frame();
		if ($urandom_range(0, 5) == 0)
			aim_x = pick_aim();
		if ($urandom_range(0, 5) == 0)
			aim_y = pick_aim();
		if ($urandom_range(0, 9) == 0)
			send_frame(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		else
			send_frame(16'(clamp_code(aim_x + int'($urandom_range(0, 8)) - 4)),
				16'(clamp_code(aim_y + int'($urandom_range(0, 8)) - 4)),
				battery_code(), battery_code());
	endtask

	task automatic drain();
		frame_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// The result side stalls in bursts; calm phases start no new stalls, so ready stays high once any stall has run out.
	initial begin : result_sink
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && $urandom_range(0, 3) == 0)
				stall_left = idle_len();
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int fs_pick;
		int dz_pick;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		frame_ch.valid <= 1'b0;
		frame_ch.axis_x_sample <= '0;
		frame_ch.axis_y_sample <= '0;
		frame_ch.battery_one_sample <= '0;
		frame_ch.battery_two_sample <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		reg_access(1'b0, ADDR_FULL_SCALE, '0);
		reg_access(1'b0, ADDR_DEAD_ZONE, '0);

		// The first frame fills every slot, so its extremes come out unfiltered.
		send_frame(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
		repeat (8) send_frame(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
		// Centre 2047, band 100: both axes sit exactly on the dead-band rims.
		repeat (8) send_frame(16'd2147, 16'd1947, 16'h5555, 16'hAAAA);
		repeat (8) send_frame(16'd2167, 16'd1927, 16'h00FF, 16'hFF00);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0: begin fs_pick = 65535; dz_pick = 0; end
				1: begin fs_pick = 2; dz_pick = 0; end
				2: begin fs_pick = 4095; dz_pick = 32767; end
				3: begin fs_pick = 0; dz_pick = 0; end
				4: begin fs_pick = 1; dz_pick = 3; end
				5: begin fs_pick = 65535; dz_pick = 32767; end
				6: begin fs_pick = 1000; dz_pick = 499; end
				7: begin fs_pick = 1000; dz_pick = 500; end
				8: begin fs_pick = 4095; dz_pick = 100; end
				default: begin
					fs_pick = $urandom_range(2, 65535);
					if ($urandom_range(0, 3) == 0)
						dz_pick = $urandom_range(0, 32767);
					else
						dz_pick = $urandom_range(0, fs_pick / 2);
				end
			endcase
			reg_access(1'b1, ADDR_FULL_SCALE, 32'(fs_pick));
			reg_access(1'b1, ADDR_DEAD_ZONE, 32'(dz_pick));
			reg_access(1'b0, ADDR_FULL_SCALE, '0);
			reg_access(1'b0, ADDR_DEAD_ZONE, '0);
			scale = fs_pick;
			band = dz_pick;
			calm = ($urandom_range(0, 3) == 0);
			aim_x = pick_aim();
			aim_y = pick_aim();
			repeat (FRAMES_PER_PHASE) send_random_frame();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && outstanding == 0)
			$display("tb_joystick_moving_average_deadzone: done, clean");
		else
			$display("tb_joystick_moving_average_deadzone: done, errors");
		$finish;
	end

endmodule
